/* rtl/moving_target_defence_policy_top_macros.svh */
// Assertion helpers for the policy block.
`ifndef MOVING_TARGET_DEFENCE_POLICY_TOP_MACROS_SVH
`define MOVING_TARGET_DEFENCE_POLICY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MTDP_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("mtdp assertion failed");
`define MTDP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtdp assertion failed");
`else
`define MTDP_ASSERT(lbl, clk, rst, expr)
`define MTDP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/mtdp_pkg.sv */
package mtdp_pkg;

   localparam int TIMER_BITS = 16;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
   localparam logic [15:0] PKT_MAX = 16'hFFFF;
   localparam logic [7:0] CNT_MAX = 8'hFF;
   localparam logic [1:0] GRACE_HOPS = 2'd2;
   localparam int FIFO_DEPTH = 2;
   localparam int MAX_RES = 3;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_REPORT = 2'd1,
      CMD_PACKET = 2'd2,
      CMD_NOP = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_STALE = 2'd0,
      KIND_CONN = 2'd1,
      KIND_LOAD = 2'd2,
      KIND_BAD = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ACT_NONE = 3'd0,
      ACT_PRO_SHUFFLE = 3'd1,
      ACT_PRO_HOP = 3'd2,
      ACT_RE_SHUFFLE = 3'd3,
      ACT_RE_HOP = 3'd4,
      ACT_FLOOD_ARM = 3'd5,
      ACT_VERDICT = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      REG_SHUFFLE_IVL = 3'd0,
      REG_HOP_IVL = 3'd1,
      REG_THREAT_THR = 3'd2,
      REG_COOLDOWN = 3'd3,
      REG_FLOOD_WIN = 3'd4,
      REG_FLOOD_THR = 3'd5,
      REG_RATE_LIMIT = 3'd6,
      REG_INIT_PORT = 3'd7
   } reg_idx_type;

   localparam logic [15:0] RST_SHUFFLE_IVL = 16'd120;
   localparam logic [15:0] RST_HOP_IVL = 16'd60;
   localparam logic [7:0] RST_THREAT_THR = 8'd5;
   localparam logic [15:0] RST_COOLDOWN = 16'd30;
   localparam logic [15:0] RST_FLOOD_WIN = 16'd10;
   localparam logic [15:0] RST_FLOOD_THR = 16'd50;
   localparam logic [15:0] RST_RATE_LIMIT = 16'd10;
   localparam logic [15:0] RST_INIT_PORT = 16'd8765;

   typedef struct packed {
      logic flood_on;
      logic grace_on;
      logic [15:0] port_before;
      logic [15:0] port_now;
      logic drop;
      logic [2:0] action;
   } res_type;

   typedef struct packed {
      res_type [MAX_RES-1:0] res;
      logic [1:0] cnt;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   function automatic logic [15:0] interval_of(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   function automatic res_type make_res(input action_type act, input logic drop,
                                        input logic [15:0] pc, input logic [15:0] pp,
                                        input logic bg, input logic lim);
      res_type r;
      r.action = act;
      r.drop = drop;
      r.port_now = pc;
      r.port_before = pp;
      r.grace_on = bg;
      r.flood_on = lim;
      return r;
   endfunction

endpackage

/* rtl/mtdp_front.sv */
module mtdp_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [1:0] cmd,
   input  logic [1:0] anomaly_kind,
   input  logic [15:0] next_port,
   input  logic csr_valid,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_data,
   input  mtdp_pkg::fifo_stat_type fifo_stat,
   output logic push,
   output mtdp_pkg::bundle_type push_data
);
   import mtdp_pkg::*;

   logic [15:0] shuffle_ivl_ff, hop_ivl_ff, cooldown_ff, flood_win_ff;
   logic [15:0] flood_thr_ff, rate_limit_ff;
   logic [7:0] threat_thr_ff;

   logic [15:0] shuffle_left_ff, hop_left_ff, flood_left_ff;
   logic [15:0] flood_pkts_ff, second_pkts_ff;
   logic [7:0] kc0_ff, kc1_ff, kc2_ff, total_ff;
   logic [TIMER_BITS-1:0] since_ff;
   logic no_yet_ff, lim_ff, grace_ff;
   logic [15:0] port_cur_ff, port_prev_ff;
   logic [1:0] hops_ff;

   logic [15:0] shuffle_left_in, hop_left_in, flood_left_in;
   logic [15:0] flood_pkts_in, second_pkts_in;
   logic [7:0] kc0_in, kc1_in, kc2_in, total_in;
   logic [TIMER_BITS-1:0] since_in;
   logic no_yet_in, lim_in, grace_in;
   logic [15:0] port_cur_in, port_prev_in;
   logic [1:0] hops_in;
   bundle_type bundle;

   assign in_ready = !fifo_stat.full;
   assign push = in_valid && in_ready;
   assign push_data = bundle;

   // Item evaluated in one pass; results snapshot state in policy order.
   always_comb begin
      logic do_rep;
      logic [1:0] rep_kind;
      logic severe;
      logic fire;
      logic drop;
      logic [1:0] n;
      shuffle_left_in = shuffle_left_ff;
      hop_left_in = hop_left_ff;
      flood_left_in = flood_left_ff;
      flood_pkts_in = flood_pkts_ff;
      second_pkts_in = second_pkts_ff;
      kc0_in = kc0_ff;
      kc1_in = kc1_ff;
      kc2_in = kc2_ff;
      total_in = total_ff;
      since_in = since_ff;
      no_yet_in = no_yet_ff;
      lim_in = lim_ff;
      grace_in = grace_ff;
      port_cur_in = port_cur_ff;
      port_prev_in = port_prev_ff;
      hops_in = hops_ff;
      bundle = '0;
      n = 2'd0;
      do_rep = 1'b0;
      rep_kind = anomaly_kind;
      severe = 1'b0;
      fire = 1'b0;
      drop = 1'b0;

      if (cmd == CMD_TICK) begin
         second_pkts_in = 16'd0;
         if (since_in < TIMER_MAX) since_in = since_in + 1'b1;
         if (shuffle_left_in <= 16'd1) begin
            shuffle_left_in = interval_of(shuffle_ivl_ff);
            bundle.res[n] = make_res(ACT_PRO_SHUFFLE, 1'b0, port_cur_in, port_prev_in,
                                     grace_in, lim_in);
            n = n + 2'd1;
         end else begin
            shuffle_left_in = shuffle_left_in - 16'd1;
         end
         if (hop_left_in <= 16'd1) begin
            hop_left_in = interval_of(hop_ivl_ff);
            if (hops_in < GRACE_HOPS) hops_in = hops_in + 2'd1;
            port_prev_in = port_cur_in;
            port_cur_in = next_port;
            if (hops_in >= GRACE_HOPS) grace_in = 1'b0;
            bundle.res[n] = make_res(ACT_PRO_HOP, 1'b0, port_cur_in, port_prev_in,
                                     grace_in, lim_in);
            n = n + 2'd1;
         end else begin
            hop_left_in = hop_left_in - 16'd1;
         end
         if (flood_left_in <= 16'd1) begin
            flood_left_in = interval_of(flood_win_ff);
            flood_pkts_in = 16'd0;
            if (flood_pkts_ff > flood_thr_ff) begin
               do_rep = 1'b1;
               rep_kind = KIND_LOAD;
            end else begin
               lim_in = 1'b0;
            end
         end else begin
            flood_left_in = flood_left_in - 16'd1;
         end
      end else if (cmd == CMD_REPORT) begin
         do_rep = (anomaly_kind != KIND_BAD);
      end else if (cmd == CMD_PACKET) begin
         if (flood_pkts_in < PKT_MAX) flood_pkts_in = flood_pkts_in + 16'd1;
         if (lim_in) begin
            if (second_pkts_in < PKT_MAX) second_pkts_in = second_pkts_in + 16'd1;
            drop = second_pkts_in > rate_limit_ff;
         end
         bundle.res[n] = make_res(ACT_VERDICT, drop, port_cur_in, port_prev_in,
                                  grace_in, lim_in);
         n = n + 2'd1;
      end

      if (do_rep) begin
         case (rep_kind)
            KIND_STALE: if (kc0_in < CNT_MAX) kc0_in = kc0_in + 8'd1;
            KIND_CONN:  if (kc1_in < CNT_MAX) kc1_in = kc1_in + 8'd1;
            default:    if (kc2_in < CNT_MAX) kc2_in = kc2_in + 8'd1;
         endcase
         if (total_in < CNT_MAX) total_in = total_in + 8'd1;
         severe = (rep_kind == KIND_CONN) || (rep_kind == KIND_LOAD);
         fire = (severe || total_in >= threat_thr_ff) &&
                (no_yet_in || since_in >= cooldown_ff);
         if (fire) begin
            since_in = '0;
            no_yet_in = 1'b0;
            if (kc1_in != 8'd0) begin
               if (hops_in < GRACE_HOPS) hops_in = hops_in + 2'd1;
               port_prev_in = port_cur_in;
               port_cur_in = next_port;
               if (hops_in >= GRACE_HOPS) grace_in = 1'b0;
               hop_left_in = interval_of(hop_ivl_ff);
               bundle.res[n] = make_res(ACT_RE_HOP, 1'b0, port_cur_in, port_prev_in,
                                        grace_in, lim_in);
            end else if (kc2_in != 8'd0) begin
               lim_in = 1'b1;
               shuffle_left_in = interval_of(shuffle_ivl_ff);
               bundle.res[n] = make_res(ACT_FLOOD_ARM, 1'b0, port_cur_in, port_prev_in,
                                        grace_in, lim_in);
            end else begin
               shuffle_left_in = interval_of(shuffle_ivl_ff);
               bundle.res[n] = make_res(ACT_RE_SHUFFLE, 1'b0, port_cur_in, port_prev_in,
                                        grace_in, lim_in);
            end
            n = n + 2'd1;
            kc0_in = 8'd0;
            kc1_in = 8'd0;
            kc2_in = 8'd0;
            total_in = 8'd0;
         end
      end

      if (n == 2'd0) begin
         bundle.res[0] = make_res(ACT_NONE, 1'b0, port_cur_in, port_prev_in,
                                  grace_in, lim_in);
         n = 2'd1;
      end
      bundle.cnt = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shuffle_ivl_ff <= RST_SHUFFLE_IVL;
         hop_ivl_ff <= RST_HOP_IVL;
         threat_thr_ff <= RST_THREAT_THR;
         cooldown_ff <= RST_COOLDOWN;
         flood_win_ff <= RST_FLOOD_WIN;
         flood_thr_ff <= RST_FLOOD_THR;
         rate_limit_ff <= RST_RATE_LIMIT;
      end else if (csr_valid) begin
         unique case (reg_idx_type'(csr_index))
            REG_SHUFFLE_IVL: shuffle_ivl_ff <= csr_data;
            REG_HOP_IVL:     hop_ivl_ff <= csr_data;
            REG_THREAT_THR:  threat_thr_ff <= csr_data[7:0];
            REG_COOLDOWN:    cooldown_ff <= csr_data;
            REG_FLOOD_WIN:   flood_win_ff <= csr_data;
            REG_FLOOD_THR:   flood_thr_ff <= csr_data;
            REG_RATE_LIMIT:  rate_limit_ff <= csr_data;
            // ports only start from the reset value; a later write changes nothing
            REG_INIT_PORT:   ;
            default: ;
         endcase
      end
   end

   // Ports start at the reset value of initial_port; after that they move by hops.
   always_ff @(posedge clock) begin
      if (reset) begin
         shuffle_left_ff <= RST_SHUFFLE_IVL;
         hop_left_ff <= RST_HOP_IVL;
         flood_left_ff <= RST_FLOOD_WIN;
         flood_pkts_ff <= '0;
         second_pkts_ff <= '0;
         kc0_ff <= '0;
         kc1_ff <= '0;
         kc2_ff <= '0;
         total_ff <= '0;
         since_ff <= '0;
         no_yet_ff <= 1'b1;
         lim_ff <= 1'b0;
         grace_ff <= 1'b1;
         port_cur_ff <= RST_INIT_PORT;
         port_prev_ff <= RST_INIT_PORT;
         hops_ff <= '0;
      end else if (push) begin
         shuffle_left_ff <= shuffle_left_in;
         hop_left_ff <= hop_left_in;
         flood_left_ff <= flood_left_in;
         flood_pkts_ff <= flood_pkts_in;
         second_pkts_ff <= second_pkts_in;
         kc0_ff <= kc0_in;
         kc1_ff <= kc1_in;
         kc2_ff <= kc2_in;
         total_ff <= total_in;
         since_ff <= since_in;
         no_yet_ff <= no_yet_in;
         lim_ff <= lim_in;
         grace_ff <= grace_in;
         port_cur_ff <= port_cur_in;
         port_prev_ff <= port_prev_in;
         hops_ff <= hops_in;
      end
   end
endmodule

/* rtl/mtdp_fifo.sv */
module mtdp_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  mtdp_pkg::bundle_type push_data,
   input  logic pop,
   output mtdp_pkg::bundle_type head,
   output mtdp_pkg::fifo_stat_type stat
);
   import mtdp_pkg::*;

   bundle_type mem_ff [FIFO_DEPTH];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign head = mem_ff[rd_ptr_ff];
   assign stat.full = (count_ff == 2'(FIFO_DEPTH));
   assign stat.empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end
endmodule

/* rtl/mtdp_back.sv */
module mtdp_back (
   input  logic clock,
   input  logic reset,
   input  mtdp_pkg::bundle_type head,
   input  mtdp_pkg::fifo_stat_type stat,
   output logic pop,
   output logic out_valid,
   input  logic out_ready,
   output mtdp_pkg::res_type out_res,
   output logic out_last
);
   import mtdp_pkg::*;

   logic [1:0] idx_ff;
   logic valid_ff, last_ff;
   res_type res_ff;
   logic load, is_last;
   res_type sel;

   always_comb begin
      case (idx_ff)
         2'd0: sel = head.res[0];
         2'd1: sel = head.res[1];
         default: sel = head.res[2];
      endcase
   end

   assign load = !stat.empty && (!valid_ff || out_ready);
   assign is_last = (idx_ff == head.cnt - 2'd1);
   assign pop = load && is_last;
   assign out_valid = valid_ff;
   assign out_res = res_ff;
   assign out_last = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= sel;
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
         if (load) idx_ff <= is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end
endmodule

/* rtl/moving_target_defence_policy_top.sv */
// Moving-target policy engine. A new item is taken every cycle while the
// two-entry result queue has room; the front updates all policy state for the
// item in that cycle. The back sends one result per cycle while rsp_tready is
// high, so an item yields one result (report, packet, idle) up to three (a tick
// that shuffles, hops and fires a response); sustained rate is set by
// that one-result-per-cycle output stage. Configuration writes are always
// taken (csr_ready is tied high) and take effect on the next item.
`include "moving_target_defence_policy_top_macros.svh"
module moving_target_defence_policy_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [1:0] cmd, [3:2] anomaly_kind, [19:4] next_port, [23:20] zero
   input  logic [23:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [2:0] action, [3] drop, [19:4] port_now, [35:20] port_before,
   // [36] grace_on, [37] flood_on, [39:38] zero
   output logic [39:0] rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_data
);
   import mtdp_pkg::*;

   fifo_stat_type fifo_stat;
   bundle_type push_data, head;
   logic push, pop;
   res_type out_res;

   assign csr_ready = 1'b1;

   mtdp_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .cmd(req_tdata[1:0]), .anomaly_kind(req_tdata[3:2]),
      .next_port(req_tdata[19:4]),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .fifo_stat(fifo_stat), .push(push), .push_data(push_data)
   );

   mtdp_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data),
      .pop(pop), .head(head), .stat(fifo_stat)
   );

   mtdp_back u_back (
      .clock(clock), .reset(reset),
      .head(head), .stat(fifo_stat), .pop(pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_res(out_res), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_res};

   `MTDP_ASSERT(a_no_push_full, clock, reset, !(push && fifo_stat.full))
   `MTDP_ASSERT(a_no_pop_empty, clock, reset, !(pop && fifo_stat.empty))
   `MTDP_ASSERT(a_bundle_cnt, clock, reset, !push || (push_data.cnt != 2'd0))
   `MTDP_ASSERT_NEXT(a_pop_last, clock, reset, pop, rsp_tvalid && rsp_tlast)
endmodule
